// ----- rtl/core/rfl_pkg.sv -----
package rfl_pkg;

  // Field widths
  localparam int SIZE_W      = 12;
  localparam int ALIGN_W     = 3;
  localparam int IDX_OUT_W   = 5;
  localparam int TOTAL_W     = 18;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;
  localparam int IN_PAD_W    = IN_TDATA_W - SIZE_W - ALIGN_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_OUT_W - 2 * TOTAL_W;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Parameter defaults
  localparam int MAX_FIELDS_DEF     = 32;
  localparam int MAX_ALIGN_LOG2_DEF = 4;

  // Controller -> datapath
  typedef struct packed {
    logic store;        // write field into stores, advance running total
    logic drop;         // field beyond capacity
    logic out_inorder;  // load result of an in-order field
    logic out_close;    // load closing result for a dropped last field
    logic clear;        // end of record
    logic walk_start;   // begin compaction walk
    logic walk_step;    // process entry presented by the store
    logic emit_start;   // begin result emission
    logic emit_load;    // load result of current entry, step index
  } rfl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic has_room;
    logic out_free;
    logic j_zero;
    logic k_zero;
    logic emit_last;
  } rfl_sts_t;

  // Round up to a multiple of 2**lg, saturating
  function automatic logic [TOTAL_W-1:0] align_up(input logic [TOTAL_W-1:0] v,
                                                  input logic [ALIGN_W-1:0] lg);
    logic [6:0]       mask;
    logic [TOTAL_W:0] sum;
    logic [TOTAL_W:0] r;
    mask = (7'(1) << lg) - 7'(1);
    sum  = {1'b0, v} + (TOTAL_W+1)'(mask);
    r    = sum & ~((TOTAL_W+1)'(mask));
    return r[TOTAL_W] ? TOTAL_MAX : r[TOTAL_W-1:0];
  endfunction

  function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                 input logic [SIZE_W-1:0] b);
    logic [TOTAL_W:0] s;
    s = {1'b0, a} + (TOTAL_W+1)'(b);
    return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
  endfunction

endpackage

// ----- rtl/core/rfl_ram.sv -----
module rfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/rfl_ctrl.sv -----
module rfl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  rfl_pkg::rfl_sts_t sts_i,
  output rfl_pkg::rfl_cmd_t cmd_o
);

  import rfl_pkg::*;

  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_WALK_RD = 3'd1;
  localparam logic [2:0] ST_WALK_EX = 3'd2;
  localparam logic [2:0] ST_EMIT_RD = 3'd3;
  localparam logic [2:0] ST_EMIT_WR = 3'd4;

  logic [2:0] state_q, state_d;
  logic       compact_q;
  logic       accept;

  assign in_ready_o = (state_q == ST_LOAD) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        if (accept) begin
          cmd_o.store = sts_i.has_room;
          cmd_o.drop  = !sts_i.has_room;
          if (!compact_q) begin
            cmd_o.out_inorder = sts_i.has_room;
            cmd_o.out_close   = !sts_i.has_room && in_last_i;
            cmd_o.clear       = in_last_i;
          end else if (in_last_i) begin
            cmd_o.walk_start = 1'b1;
            state_d          = ST_WALK_RD;
          end
        end
      end
      ST_WALK_RD: begin
        state_d = ST_WALK_EX;
      end
      ST_WALK_EX: begin
        cmd_o.walk_step = 1'b1;
        if (sts_i.j_zero && sts_i.k_zero) begin
          cmd_o.emit_start = 1'b1;
          state_d          = ST_EMIT_RD;
        end else begin
          state_d = ST_WALK_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_WR;
      end
      ST_EMIT_WR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      compact_q <= 1'b1;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        compact_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ----- rtl/core/rfl_dp.sv -----
module rfl_dp #(
  parameter int MAX_FIELDS     = rfl_pkg::MAX_FIELDS_DEF,
  parameter int MAX_ALIGN_LOG2 = rfl_pkg::MAX_ALIGN_LOG2_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rfl_pkg::rfl_cmd_t             cmd_i,
  output rfl_pkg::rfl_sts_t             sts_o,
  input  logic [rfl_pkg::SIZE_W-1:0]    in_size_i,
  input  logic [rfl_pkg::ALIGN_W-1:0]   in_align_i,
  input  logic                          in_last_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [rfl_pkg::IDX_OUT_W-1:0] out_idx_o,
  output logic [rfl_pkg::TOTAL_W-1:0]   out_offset_o,
  output logic [rfl_pkg::TOTAL_W-1:0]   out_total_o,
  output logic                          out_ovf_o,
  output logic                          out_last_o
);

  import rfl_pkg::*;

  localparam int IDX_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
  localparam int CNT_W = $clog2(MAX_FIELDS + 1);
  localparam logic [ALIGN_W-1:0] ALIGN_MAX = ALIGN_W'(MAX_ALIGN_LOG2);

  // record state
  logic [TOTAL_W-1:0] rt_q, rt_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               ovf_q, ovf_d;
  // walk / emit state
  logic [IDX_W-1:0]   j_q, j_d;
  logic [ALIGN_W-1:0] k_q, k_d;
  logic [TOTAL_W-1:0] tot_q, tot_d;
  logic               placed_q, placed_d;
  // result register
  logic                 ovalid_q, ovalid_d;
  logic [IDX_OUT_W-1:0] oidx_q, oidx_d;
  logic [TOTAL_W-1:0]   ooff_q, ooff_d;
  logic [TOTAL_W-1:0]   otot_q, otot_d;
  logic                 oovf_q, oovf_d;
  logic                 olast_q, olast_d;

  logic [ALIGN_W-1:0]        lg_sat;
  logic [TOTAL_W-1:0]        load_off;
  logic [TOTAL_W-1:0]        load_tot;
  logic [CNT_W-1:0]          cnt_next;
  logic [CNT_W-1:0]          cnt_last;
  logic [SIZE_W+ALIGN_W-1:0] fld_rd;
  logic [SIZE_W-1:0]         rd_size;
  logic [ALIGN_W-1:0]        rd_align;
  logic [TOTAL_W-1:0]        rd_off;
  logic                      hit;
  logic [TOTAL_W-1:0]        walk_t0;
  logic                      off_we;
  logic [IDX_W-1:0]          off_waddr;
  logic [TOTAL_W-1:0]        off_wdata;
  logic                      out_free;

  assign lg_sat   = (in_align_i > ALIGN_MAX) ? ALIGN_MAX : in_align_i;
  assign load_off = align_up(rt_q, lg_sat);
  assign load_tot = sat_add(load_off, in_size_i);
  assign cnt_next = count_q + CNT_W'(cmd_i.store);
  assign cnt_last = count_q - CNT_W'(1);

  assign rd_size  = fld_rd[SIZE_W-1:0];
  assign rd_align = fld_rd[SIZE_W+ALIGN_W-1:SIZE_W];
  assign hit      = (rd_align == k_q);
  assign walk_t0  = placed_q ? tot_q : align_up(tot_q, k_q);

  assign off_we    = cmd_i.store || (cmd_i.walk_step && hit);
  assign off_waddr = cmd_i.store ? IDX_W'(count_q) : j_q;
  assign off_wdata = cmd_i.store ? load_off : walk_t0;

  rfl_ram #(
    .WIDTH (SIZE_W + ALIGN_W),
    .DEPTH (MAX_FIELDS)
  ) u_fld_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.store),
    .waddr_i (IDX_W'(count_q)),
    .wdata_i ({lg_sat, in_size_i}),
    .raddr_i (j_q),
    .rdata_o (fld_rd)
  );

  rfl_ram #(
    .WIDTH (TOTAL_W),
    .DEPTH (MAX_FIELDS)
  ) u_off_ram (
    .clk_i   (clk_i),
    .we_i    (off_we),
    .waddr_i (off_waddr),
    .wdata_i (off_wdata),
    .raddr_i (j_q),
    .rdata_o (rd_off)
  );

  assign out_free = !ovalid_q || out_ready_i;

  assign sts_o.has_room  = (count_q < CNT_W'(MAX_FIELDS));
  assign sts_o.out_free  = out_free;
  assign sts_o.j_zero    = (j_q == '0);
  assign sts_o.k_zero    = (k_q == '0);
  assign sts_o.emit_last = (CNT_W'(j_q) == cnt_last);

  always_comb begin
    rt_d     = rt_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    j_d      = j_q;
    k_d      = k_q;
    tot_d    = tot_q;
    placed_d = placed_q;

    if (cmd_i.store) begin
      rt_d    = load_tot;
      count_d = cnt_next;
    end
    if (cmd_i.drop) begin
      ovf_d = 1'b1;
    end

    if (cmd_i.walk_start) begin
      j_d      = IDX_W'(cnt_next - CNT_W'(1));
      k_d      = ALIGN_MAX;
      tot_d    = '0;
      placed_d = 1'b0;
    end else if (cmd_i.walk_step) begin
      if (hit) begin
        tot_d    = sat_add(walk_t0, rd_size);
        placed_d = 1'b1;
      end
      if (j_q == '0) begin
        if (k_q != '0) begin
          // next weaker alignment class, highest index first
          k_d      = k_q - ALIGN_W'(1);
          j_d      = IDX_W'(cnt_last);
          placed_d = 1'b0;
        end
      end else begin
        j_d = j_q - IDX_W'(1);
      end
    end

    if (cmd_i.emit_start) begin
      j_d = '0;
    end else if (cmd_i.emit_load) begin
      j_d = j_q + IDX_W'(1);
    end

    if (cmd_i.clear) begin
      rt_d    = '0;
      count_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_comb begin
    ovalid_d = ovalid_q && !out_ready_i;
    oidx_d   = oidx_q;
    ooff_d   = ooff_q;
    otot_d   = otot_q;
    oovf_d   = oovf_q;
    olast_d  = olast_q;
    if (cmd_i.out_inorder) begin
      ovalid_d = 1'b1;
      oidx_d   = IDX_OUT_W'(count_q);
      ooff_d   = load_off;
      otot_d   = load_tot;
      oovf_d   = ovf_q;
      olast_d  = in_last_i;
    end else if (cmd_i.out_close) begin
      ovalid_d = 1'b1;
      oidx_d   = '0;
      ooff_d   = '0;
      otot_d   = rt_q;
      oovf_d   = 1'b1;
      olast_d  = 1'b1;
    end else if (cmd_i.emit_load) begin
      ovalid_d = 1'b1;
      oidx_d   = IDX_OUT_W'(j_q);
      ooff_d   = rd_off;
      otot_d   = tot_q;
      oovf_d   = ovf_q;
      olast_d  = sts_o.emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_q     <= '0;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      rt_q     <= rt_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    j_q      <= j_d;
    k_q      <= k_d;
    tot_q    <= tot_d;
    placed_q <= placed_d;
    oidx_q   <= oidx_d;
    ooff_q   <= ooff_d;
    otot_q   <= otot_d;
    oovf_q   <= oovf_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o  = ovalid_q;
  assign out_idx_o    = oidx_q;
  assign out_offset_o = ooff_q;
  assign out_total_o  = otot_q;
  assign out_ovf_o    = oovf_q;
  assign out_last_o   = olast_q;

endmodule

// ----- rtl/core/record_field_layout.sv -----
// In-order mode: result of a field is valid the cycle after its transfer; 1 field/cycle while the
// output is not stalled. Compact mode: fields load 1/cycle while the output is not stalled; after
//   the last field the layout walk reads the store once per class and entry (N stored fields),
//   then results leave one per entry through emit read and write states, held by any output stall.
// Reset (rst_ni low, async): record cleared, result register empty, compact_mode = 1.
// Field stores have no reset; only entries written in the current record are read.
module record_field_layout #(
  parameter int MAX_FIELDS     = rfl_pkg::MAX_FIELDS_DEF,
  parameter int MAX_ALIGN_LOG2 = rfl_pkg::MAX_ALIGN_LOG2_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: compact_mode
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  // field stream in
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [11:0] elem_size, [14:12] elem_align_log2, [15] zero
  input  logic [rfl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  logic                              s_axis_tlast,   // last_elem
  // layout stream out
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [4:0] elem_index, [22:5] elem_offset, [40:23] record_size, [47:41] zero
  output logic [rfl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  output logic                              m_axis_tuser,   // overflow
  output logic                              m_axis_tlast    // last_result
);

  import rfl_pkg::*;

  rfl_cmd_t cmd;
  rfl_sts_t sts;

  logic [IDX_OUT_W-1:0] out_idx;
  logic [TOTAL_W-1:0]   out_offset;
  logic [TOTAL_W-1:0]   out_total;

  // Controller: mode register, load / walk / emit sequencing
  rfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: field stores, running total, walk counters, result register
  rfl_dp #(
    .MAX_FIELDS     (MAX_FIELDS),
    .MAX_ALIGN_LOG2 (MAX_ALIGN_LOG2)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_size_i    (s_axis_tdata[SIZE_W-1:0]),
    .in_align_i   (s_axis_tdata[SIZE_W+ALIGN_W-1:SIZE_W]),
    .in_last_i    (s_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_idx_o    (out_idx),
    .out_offset_o (out_offset),
    .out_total_o  (out_total),
    .out_ovf_o    (m_axis_tuser),
    .out_last_o   (m_axis_tlast)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, out_total, out_offset, out_idx};

  // At most one source loads the result register per cycle
  a_out_load_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.out_inorder, cmd.out_close, cmd.emit_load}))
    else $error("multiple result loads in one cycle");

  // A pending result is never overwritten
  a_out_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_inorder || cmd.out_close || cmd.emit_load) |-> sts.out_free)
    else $error("result register overwritten while held");

  // Input is closed while a compact layout is in progress
  a_walk_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.walk_start |=> !s_axis_tready)
    else $error("input open during layout walk");

  // The final emitted entry closes the record
  a_emit_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.emit_load && sts.emit_last) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("record end not marked on final result");

endmodule
